### rtl/core/lru_key_value_cache_defines.svh
// Assertion helpers for the cache RTL
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// expression holds at every rising clock edge outside reset
`define LKVC_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define LKVC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/lkvc_pkg.sv
package lkvc_pkg;

   localparam int OP_WIDTH     = 4;
   localparam int STATUS_WIDTH = 2;
   localparam int OCC_WIDTH    = 5;
   localparam int CAP_WIDTH    = 5;

   typedef logic [OP_WIDTH-1:0] op_type;
   localparam op_type OP_GET         = 4'd0;
   localparam op_type OP_PUT         = 4'd1;
   localparam op_type OP_DELETE      = 4'd2;
   localparam op_type OP_POP         = 4'd3;
   localparam op_type OP_CONTAINS    = 4'd4;
   localparam op_type OP_POP_OLDEST  = 4'd5;
   localparam op_type OP_POP_NEWEST  = 4'd6;
   localparam op_type OP_PEEK_NEWEST = 4'd7;
   localparam op_type OP_PEEK_OLDEST = 4'd8;
   localparam op_type OP_CLEAR       = 4'd9;
   localparam op_type OP_LIST        = 4'd10;

   typedef logic [STATUS_WIDTH-1:0] status_type;
   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_MISSING = 2'd1;
   localparam status_type ST_EMPTY   = 2'd2;

   typedef logic [2:0] cell_cmd_type;
   localparam cell_cmd_type CELL_HOLD      = 3'd0;
   localparam cell_cmd_type CELL_TAKE_PREV = 3'd1;
   localparam cell_cmd_type CELL_TAKE_NEXT = 3'd2;
   localparam cell_cmd_type CELL_LOAD      = 3'd3;
   localparam cell_cmd_type CELL_KILL      = 3'd4;

   typedef struct packed {
      cell_cmd_type cmd;
   } cell_ctl_type;

   typedef struct packed {
      logic valid;
      logic match;
   } cell_stat_type;

endpackage

### rtl/core/lkvc_if.sv
interface lkvc_req_if #(
   parameter int KEY_WIDTH   = 32,
   parameter int VALUE_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic [lkvc_pkg::OP_WIDTH-1:0] operation;
   logic [KEY_WIDTH-1:0]          key_in;
   logic [VALUE_WIDTH-1:0]        value_in;

   modport source (output valid, operation, key_in, value_in, input ready);
   modport sink (input valid, operation, key_in, value_in, output ready);
endinterface

interface lkvc_rsp_if #(
   parameter int KEY_WIDTH   = 32,
   parameter int VALUE_WIDTH = 32,
   parameter int COUNT_WIDTH = 32
);
   logic                              valid;
   logic                              ready;
   logic                              found;
   logic [KEY_WIDTH-1:0]              key_out;
   logic [VALUE_WIDTH-1:0]            value_out;
   logic                              evicted;
   logic [KEY_WIDTH-1:0]              evicted_key;
   logic [VALUE_WIDTH-1:0]            evicted_value;
   logic [lkvc_pkg::STATUS_WIDTH-1:0] status;
   logic [COUNT_WIDTH-1:0]            hit_count;
   logic [COUNT_WIDTH-1:0]            miss_count;
   logic [lkvc_pkg::OCC_WIDTH-1:0]    occupancy;
   logic                              last_result;

   modport source (output valid, found, key_out, value_out, evicted, evicted_key,
                   evicted_value, status, hit_count, miss_count, occupancy,
                   last_result, input ready);
   modport sink (input valid, found, key_out, value_out, evicted, evicted_key,
                 evicted_value, status, hit_count, miss_count, occupancy,
                 last_result, output ready);
endinterface

### rtl/core/lkvc_cell.sv
module lkvc_cell #(
   parameter int KEY_WIDTH   = 32,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lkvc_pkg::cell_ctl_type ctl,
   input  logic [KEY_WIDTH-1:0]   probe_key,
   input  logic [KEY_WIDTH-1:0]   load_key,
   input  logic [VALUE_WIDTH-1:0] load_value,
   input  logic                   prev_valid,
   input  logic [KEY_WIDTH-1:0]   prev_key,
   input  logic [VALUE_WIDTH-1:0] prev_value,
   input  logic                   next_valid,
   input  logic [KEY_WIDTH-1:0]   next_key,
   input  logic [VALUE_WIDTH-1:0] next_value,
   output lkvc_pkg::cell_stat_type stat,
   output logic [KEY_WIDTH-1:0]   key,
   output logic [VALUE_WIDTH-1:0] value
);

   logic                   valid_ff, valid_in;
   logic [KEY_WIDTH-1:0]   key_ff, key_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      value_in = value_ff;
      unique case (ctl.cmd)
         lkvc_pkg::CELL_TAKE_PREV: begin
            valid_in = prev_valid;
            key_in   = prev_key;
            value_in = prev_value;
         end
         lkvc_pkg::CELL_TAKE_NEXT: begin
            valid_in = next_valid;
            key_in   = next_key;
            value_in = next_value;
         end
         lkvc_pkg::CELL_LOAD: begin
            valid_in = 1'b1;
            key_in   = load_key;
            value_in = load_value;
         end
         lkvc_pkg::CELL_KILL: begin
            valid_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign stat.valid = valid_ff;
   assign stat.match = valid_ff && (key_ff == probe_key);
   assign key        = key_ff;
   assign value      = value_ff;

endmodule

### rtl/core/lru_key_value_cache.sv
// Fully associative LRU key-value cache built as a row of cells in recency order.
// Each request is registered, then the parallel key match and a one-position shift
// of the cell row run once the result register is free, which decouples the output.
// List emits one beat per held entry, newest first, as the output frees up.
// Reset (synchronous, active high) empties the store, zeroes the counters and sets
// capacity to the lesser of ENTRIES and 16; no clearing pass is needed.
`include "lru_key_value_cache_defines.svh"
module lru_key_value_cache #(
   parameter int ENTRIES     = 16,
   parameter int KEY_WIDTH   = 32,
   parameter int VALUE_WIDTH = 32,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   lkvc_req_if.sink                         req_ch,
   lkvc_rsp_if.source                       rsp_ch,
   input  logic                             csr_wr_en,
   input  logic [lkvc_pkg::CAP_WIDTH-1:0]   csr_wr_data
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int RESET_CAP = (ENTRIES < 16) ? ENTRIES : 16;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_LIST = 2'd2;

   logic [1:0]             state_ff, state_in;
   lkvc_pkg::op_type       op_ff;
   logic [KEY_WIDTH-1:0]   key_ff;
   logic [VALUE_WIDTH-1:0] val_ff;
   logic [CNT_W-1:0]       entries_ff, entries_in;
   logic [CNT_W-1:0]       cap_ff;
   logic [COUNT_WIDTH-1:0] hits_ff, hits_in, misses_ff, misses_in;
   logic [IDX_W-1:0]       list_idx_ff, list_idx_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              found_ff, found_in;
   logic [KEY_WIDTH-1:0]              kout_ff, kout_in;
   logic [VALUE_WIDTH-1:0]            vout_ff, vout_in;
   logic                              evict_ff, evict_in;
   logic [KEY_WIDTH-1:0]              ekey_ff, ekey_in;
   logic [VALUE_WIDTH-1:0]            eval_ff, eval_in;
   lkvc_pkg::status_type              status_ff, status_in;
   logic [COUNT_WIDTH-1:0]            hout_ff, hout_in, mout_ff, mout_in;
   logic [lkvc_pkg::OCC_WIDTH-1:0]    occ_ff, occ_in;
   logic                              last_ff, last_in;

   lkvc_pkg::cell_ctl_type  cell_ctl [ENTRIES];
   lkvc_pkg::cell_stat_type cell_stat [ENTRIES];
   logic [KEY_WIDTH-1:0]    cell_key [ENTRIES];
   logic [VALUE_WIDTH-1:0]  cell_val [ENTRIES];
   logic [ENTRIES-1:0]      valid_vec;
   logic [KEY_WIDTH-1:0]    load_key;
   logic [VALUE_WIDTH-1:0]  load_val;

   logic                   hit;
   logic [IDX_W-1:0]       hit_idx, old_idx;
   logic [VALUE_WIDTH-1:0] hit_val, old_val, new_val, list_val;
   logic [KEY_WIDTH-1:0]   old_key, list_key;
   logic                   out_free, step, accept;
   logic [CNT_W-1:0]       entries_less;
   logic                   list_last;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      logic                   pv, nv;
      logic [KEY_WIDTH-1:0]   pk, nk;
      logic [VALUE_WIDTH-1:0] pval, nval;
      if (g == 0) begin : g_first
         assign pv = 1'b0;
         assign pk = '0;
         assign pval = '0;
      end else begin : g_mid
         assign pv = cell_stat[g-1].valid;
         assign pk = cell_key[g-1];
         assign pval = cell_val[g-1];
      end
      if (g == ENTRIES - 1) begin : g_last
         assign nv = 1'b0;
         assign nk = '0;
         assign nval = '0;
      end else begin : g_inner
         assign nv = cell_stat[g+1].valid;
         assign nk = cell_key[g+1];
         assign nval = cell_val[g+1];
      end
      lkvc_cell #(.KEY_WIDTH(KEY_WIDTH), .VALUE_WIDTH(VALUE_WIDTH)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl[g]),
         .probe_key  (key_ff),
         .load_key   (load_key),
         .load_value (load_val),
         .prev_valid (pv),
         .prev_key   (pk),
         .prev_value (pval),
         .next_valid (nv),
         .next_key   (nk),
         .next_value (nval),
         .stat       (cell_stat[g]),
         .key        (cell_key[g]),
         .value      (cell_val[g])
      );
      assign valid_vec[g] = cell_stat[g].valid;
   end

   assign entries_less = entries_ff - CNT_W'(1);
   assign old_idx      = IDX_W'(entries_less);

   always_comb begin
      hit      = 1'b0;
      hit_idx  = '0;
      hit_val  = '0;
      old_key  = '0;
      old_val  = '0;
      list_key = '0;
      list_val = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (cell_stat[i].match) begin
            hit     = 1'b1;
            hit_idx = IDX_W'(i);
         end
      end
      for (int i = 0; i < ENTRIES; i++) begin
         if (IDX_W'(i) == hit_idx) hit_val = cell_val[i];
         if (IDX_W'(i) == old_idx) begin
            old_key = cell_key[i];
            old_val = cell_val[i];
         end
         if (IDX_W'(i) == list_idx_ff) begin
            list_key = cell_key[i];
            list_val = cell_val[i];
         end
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign step      = (state_ff == S_EXEC) && out_free;
   assign accept    = req_ch.valid && req_ch.ready;
   assign list_last = (CNT_W'(list_idx_ff) == entries_less);
   assign new_val   = (op_ff == lkvc_pkg::OP_PUT) ? val_ff : hit_val;
   assign load_key  = key_ff;
   assign load_val  = new_val;
   assign req_ch.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      entries_in   = entries_ff;
      hits_in      = hits_ff;
      misses_in    = misses_ff;
      list_idx_in  = list_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      found_in     = found_ff;
      kout_in      = kout_ff;
      vout_in      = vout_ff;
      evict_in     = evict_ff;
      ekey_in      = ekey_ff;
      eval_in      = eval_ff;
      status_in    = status_ff;
      hout_in      = hout_ff;
      mout_in      = mout_ff;
      occ_in       = occ_ff;
      last_in      = last_ff;
      for (int i = 0; i < ENTRIES; i++) cell_ctl[i].cmd = lkvc_pkg::CELL_HOLD;

      if (accept) state_in = S_EXEC;

      if (step) begin
         state_in     = S_IDLE;
         rsp_valid_in = 1'b1;
         found_in     = 1'b0;
         kout_in      = '0;
         vout_in      = '0;
         evict_in     = 1'b0;
         ekey_in      = '0;
         eval_in      = '0;
         status_in    = lkvc_pkg::ST_OK;
         last_in      = 1'b1;
         unique case (op_ff) inside
            lkvc_pkg::OP_GET, lkvc_pkg::OP_POP: begin
               if (!hit) begin
                  if (misses_ff != '1) misses_in = misses_ff + COUNT_WIDTH'(1);
                  status_in = lkvc_pkg::ST_MISSING;
               end else begin
                  if (hits_ff != '1) hits_in = hits_ff + COUNT_WIDTH'(1);
                  found_in = 1'b1;
                  kout_in  = key_ff;
                  vout_in  = hit_val;
                  if (op_ff == lkvc_pkg::OP_GET) begin
                     for (int i = 0; i < ENTRIES; i++) begin
                        if (i == 0) cell_ctl[i].cmd = lkvc_pkg::CELL_LOAD;
                        else if (IDX_W'(i) <= hit_idx)
                           cell_ctl[i].cmd = lkvc_pkg::CELL_TAKE_PREV;
                     end
                  end else begin
                     for (int i = 0; i < ENTRIES; i++)
                        if (IDX_W'(i) >= hit_idx) cell_ctl[i].cmd = lkvc_pkg::CELL_TAKE_NEXT;
                     entries_in = entries_less;
                  end
               end
            end
            lkvc_pkg::OP_PUT: begin
               if (hit) begin
                  found_in = 1'b1;
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (i == 0) cell_ctl[i].cmd = lkvc_pkg::CELL_LOAD;
                     else if (IDX_W'(i) <= hit_idx)
                        cell_ctl[i].cmd = lkvc_pkg::CELL_TAKE_PREV;
                  end
               end else begin
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (i == 0) cell_ctl[i].cmd = lkvc_pkg::CELL_LOAD;
                     else if (CNT_W'(i) >= cap_ff) cell_ctl[i].cmd = lkvc_pkg::CELL_KILL;
                     else cell_ctl[i].cmd = lkvc_pkg::CELL_TAKE_PREV;
                  end
                  if (entries_ff >= cap_ff && entries_ff != '0) begin
                     evict_in = 1'b1;
                     ekey_in  = old_key;
                     eval_in  = old_val;
                  end else begin
                     entries_in = entries_ff + CNT_W'(1);
                  end
               end
            end
            lkvc_pkg::OP_DELETE, lkvc_pkg::OP_CONTAINS: begin
               if (!hit) begin
                  status_in = lkvc_pkg::ST_MISSING;
               end else begin
                  found_in = 1'b1;
                  if (op_ff == lkvc_pkg::OP_DELETE) begin
                     for (int i = 0; i < ENTRIES; i++)
                        if (IDX_W'(i) >= hit_idx) cell_ctl[i].cmd = lkvc_pkg::CELL_TAKE_NEXT;
                     entries_in = entries_less;
                  end
               end
            end
            lkvc_pkg::OP_POP_OLDEST, lkvc_pkg::OP_PEEK_OLDEST: begin
               if (entries_ff == '0) begin
                  status_in = lkvc_pkg::ST_EMPTY;
               end else begin
                  found_in = 1'b1;
                  kout_in  = old_key;
                  vout_in  = old_val;
                  if (op_ff == lkvc_pkg::OP_POP_OLDEST) begin
                     for (int i = 0; i < ENTRIES; i++)
                        if (IDX_W'(i) == old_idx) cell_ctl[i].cmd = lkvc_pkg::CELL_KILL;
                     entries_in = entries_less;
                  end
               end
            end
            lkvc_pkg::OP_POP_NEWEST, lkvc_pkg::OP_PEEK_NEWEST: begin
               if (entries_ff == '0) begin
                  status_in = lkvc_pkg::ST_EMPTY;
               end else begin
                  found_in = 1'b1;
                  kout_in  = cell_key[0];
                  vout_in  = cell_val[0];
                  if (op_ff == lkvc_pkg::OP_POP_NEWEST) begin
                     for (int i = 0; i < ENTRIES; i++)
                        cell_ctl[i].cmd = lkvc_pkg::CELL_TAKE_NEXT;
                     entries_in = entries_less;
                  end
               end
            end
            lkvc_pkg::OP_CLEAR: begin
               for (int i = 0; i < ENTRIES; i++) cell_ctl[i].cmd = lkvc_pkg::CELL_KILL;
               entries_in = '0;
               hits_in    = '0;
               misses_in  = '0;
            end
            lkvc_pkg::OP_LIST: begin
               if (entries_ff == '0) begin
                  status_in = lkvc_pkg::ST_EMPTY;
               end else begin
                  // hold the output; beats come from the list state
                  rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
                  state_in     = S_LIST;
                  list_idx_in  = '0;
               end
            end
            default: begin
            end
         endcase
         hout_in = hits_in;
         mout_in = misses_in;
         occ_in  = lkvc_pkg::OCC_WIDTH'(entries_in);
      end

      if (state_ff == S_LIST && out_free) begin
         rsp_valid_in = 1'b1;
         found_in     = 1'b1;
         kout_in      = list_key;
         vout_in      = list_val;
         evict_in     = 1'b0;
         ekey_in      = '0;
         eval_in      = '0;
         status_in    = lkvc_pkg::ST_OK;
         hout_in      = hits_ff;
         mout_in      = misses_ff;
         occ_in       = lkvc_pkg::OCC_WIDTH'(entries_ff);
         last_in      = list_last;
         if (list_last) state_in = S_IDLE;
         else list_idx_in = list_idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         entries_ff   <= '0;
         cap_ff       <= CNT_W'(RESET_CAP);
         hits_ff      <= '0;
         misses_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         entries_ff   <= entries_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en && entries_ff == '0) begin
            if (csr_wr_data == '0) cap_ff <= CNT_W'(1);
            else if (int'(csr_wr_data) > ENTRIES) cap_ff <= CNT_W'(ENTRIES);
            else cap_ff <= CNT_W'(csr_wr_data);
         end
      end
      if (accept) begin
         op_ff  <= req_ch.operation;
         key_ff <= req_ch.key_in;
         val_ff <= req_ch.value_in;
      end
      list_idx_ff <= list_idx_in;
      found_ff    <= found_in;
      kout_ff     <= kout_in;
      vout_ff     <= vout_in;
      evict_ff    <= evict_in;
      ekey_ff     <= ekey_in;
      eval_ff     <= eval_in;
      status_ff   <= status_in;
      hout_ff     <= hout_in;
      mout_ff     <= mout_in;
      occ_ff      <= occ_in;
      last_ff     <= last_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.found         = found_ff;
   assign rsp_ch.key_out       = kout_ff;
   assign rsp_ch.value_out     = vout_ff;
   assign rsp_ch.evicted       = evict_ff;
   assign rsp_ch.evicted_key   = ekey_ff;
   assign rsp_ch.evicted_value = eval_ff;
   assign rsp_ch.status        = status_ff;
   assign rsp_ch.hit_count     = hout_ff;
   assign rsp_ch.miss_count    = mout_ff;
   assign rsp_ch.occupancy     = occ_ff;
   assign rsp_ch.last_result   = last_ff;

   `LKVC_ASSERT_ALWAYS(a_occ_within_cap, clock, reset, entries_ff <= cap_ff, "occupancy above capacity")
   `LKVC_ASSERT_ALWAYS(a_valid_count, clock, reset, $countones(valid_vec) == int'(entries_ff), "valid cells disagree with occupancy")
   `LKVC_ASSERT_ALWAYS(a_list_nonempty, clock, reset, (state_ff != S_LIST) || (entries_ff != '0), "list walk on empty store")
   `LKVC_ASSERT_NEXT(a_accept_exec, clock, reset, accept, state_ff == S_EXEC, "accepted beat not executed")

endmodule

### tb/lru_key_value_cache_tb.sv
`timescale 1ns / 100ps
module lru_key_value_cache_tb;

   typedef struct packed {
      logic                 found;
      logic [31:0]          key_out;
      logic [31:0]          value_out;
      logic                 evicted;
      logic [31:0]          evicted_key;
      logic [31:0]          evicted_value;
      lkvc_pkg::status_type status;
      logic [31:0]          hit_count;
      logic [31:0]          miss_count;
      logic [4:0]           occupancy;
      logic                 last_result;
   } beat_type;

   class cache_scoreboard;
      logic [31:0] keys[16];
      logic [31:0] vals[16];
      bit          vld[16];
      int unsigned rank[16];
      logic [31:0] hits, misses;
      int unsigned held, cap;
      beat_type    pending[$];
      int          mismatches;
      int          beats_checked;

      function void clear_all();
         for (int i = 0; i < 16; i++) begin
            vld[i] = 0;
            rank[i] = 0;
         end
         held = 0;
         hits = 0;
         misses = 0;
      endfunction

      function void write_capacity(logic [4:0] c);
         int unsigned v;
         v = c;
         if (held != 0) return;
         if (v < 1) v = 1;
         if (v > 16) v = 16;
         cap = v;
      endfunction

      function int find_key(logic [31:0] k);
         for (int i = 0; i < 16; i++) if (vld[i] && keys[i] == k) return i;
         return -1;
      endfunction

      function int find_rank(int unsigned r);
         for (int i = 0; i < 16; i++) if (vld[i] && rank[i] == r) return i;
         return -1;
      endfunction

      function void promote(int s);
         int unsigned r;
         r = rank[s];
         for (int i = 0; i < 16; i++) if (vld[i] && rank[i] < r) rank[i]++;
         rank[s] = 0;
      endfunction

      function void drop(int s);
         int unsigned r;
         r = rank[s];
         vld[s] = 0;
         rank[s] = 0;
         for (int i = 0; i < 16; i++) if (vld[i] && rank[i] > r) rank[i]--;
         if (held > 0) held--;
      endfunction

      function void insert(logic [31:0] k, logic [31:0] v);
         int fs;
         fs = -1;
         for (int i = 0; i < 16; i++) begin
            if (vld[i]) rank[i]++;
            else if (fs < 0) fs = i;
         end
         if (fs < 0) return;
         keys[fs] = k;
         vals[fs] = v;
         vld[fs] = 1;
         rank[fs] = 0;
         held++;
      endfunction

      function void push(bit f, logic [31:0] k, logic [31:0] v, bit ev,
                         logic [31:0] ek, logic [31:0] evv, lkvc_pkg::status_type st,
                         bit last);
         beat_type b;
         b.found = f;
         b.key_out = k;
         b.value_out = v;
         b.evicted = ev;
         b.evicted_key = ek;
         b.evicted_value = evv;
         b.status = st;
         b.hit_count = hits;
         b.miss_count = misses;
         b.occupancy = held[4:0];
         b.last_result = last;
         pending.push_back(b);
      endfunction

      function void note_request(lkvc_pkg::op_type op, logic [31:0] k, logic [31:0] v);
         int s;
         logic [31:0] rk, rv;
         case (op)
            lkvc_pkg::OP_GET, lkvc_pkg::OP_POP: begin
               s = find_key(k);
               if (s < 0) begin
                  if (misses != '1) misses++;
                  push(1'b0, '0, '0, 1'b0, '0, '0, lkvc_pkg::ST_MISSING, 1'b1);
               end else begin
                  if (hits != '1) hits++;
                  rv = vals[s];
                  if (op == lkvc_pkg::OP_GET) promote(s);
                  else drop(s);
                  push(1'b1, k, rv, 1'b0, '0, '0, lkvc_pkg::ST_OK, 1'b1);
               end
            end
            lkvc_pkg::OP_PUT: begin
               s = find_key(k);
               if (s >= 0) begin
                  vals[s] = v;
                  promote(s);
                  push(1'b1, '0, '0, 1'b0, '0, '0, lkvc_pkg::ST_OK, 1'b1);
               end else if (held >= cap && held > 0 && find_rank(held - 1) >= 0) begin
                  s = find_rank(held - 1);
                  rk = keys[s];
                  rv = vals[s];
                  drop(s);
                  insert(k, v);
                  push(1'b0, '0, '0, 1'b1, rk, rv, lkvc_pkg::ST_OK, 1'b1);
               end else begin
                  insert(k, v);
                  push(1'b0, '0, '0, 1'b0, '0, '0, lkvc_pkg::ST_OK, 1'b1);
               end
            end
            lkvc_pkg::OP_DELETE, lkvc_pkg::OP_CONTAINS: begin
               s = find_key(k);
               if (s < 0) push(1'b0, '0, '0, 1'b0, '0, '0, lkvc_pkg::ST_MISSING, 1'b1);
               else begin
                  if (op == lkvc_pkg::OP_DELETE) drop(s);
                  push(1'b1, '0, '0, 1'b0, '0, '0, lkvc_pkg::ST_OK, 1'b1);
               end
            end
            lkvc_pkg::OP_POP_OLDEST, lkvc_pkg::OP_POP_NEWEST,
            lkvc_pkg::OP_PEEK_NEWEST, lkvc_pkg::OP_PEEK_OLDEST: begin
               s = (held == 0) ? -1 :
                   find_rank((op == lkvc_pkg::OP_POP_OLDEST ||
                              op == lkvc_pkg::OP_PEEK_OLDEST) ? held - 1 : 0);
               if (s < 0) push(1'b0, '0, '0, 1'b0, '0, '0, lkvc_pkg::ST_EMPTY, 1'b1);
               else begin
                  rk = keys[s];
                  rv = vals[s];
                  if (op == lkvc_pkg::OP_POP_OLDEST || op == lkvc_pkg::OP_POP_NEWEST)
                     drop(s);
                  push(1'b1, rk, rv, 1'b0, '0, '0, lkvc_pkg::ST_OK, 1'b1);
               end
            end
            lkvc_pkg::OP_CLEAR: begin
               clear_all();
               push(1'b0, '0, '0, 1'b0, '0, '0, lkvc_pkg::ST_OK, 1'b1);
            end
            lkvc_pkg::OP_LIST: begin
               if (held == 0) push(1'b0, '0, '0, 1'b0, '0, '0, lkvc_pkg::ST_EMPTY, 1'b1);
               else
                  for (int r = 0; r < held; r++) begin
                     s = find_rank(r);
                     push(1'b1, keys[s], vals[s], 1'b0, '0, '0, lkvc_pkg::ST_OK,
                          r + 1 == held);
                  end
            end
            default: push(1'b0, '0, '0, 1'b0, '0, '0, lkvc_pkg::ST_OK, 1'b1);
         endcase
      endfunction

      function void check_beat(beat_type got);
         beat_type want;
         beats_checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch at %0t", $realtime);
               $display("  exp found=%0d key=%h val=%h ev=%0d ek=%h evv=%h st=%0d",
                        want.found, want.key_out, want.value_out, want.evicted,
                        want.evicted_key, want.evicted_value, want.status);
               $display("      hit=%0d miss=%0d occ=%0d last=%0d",
                        want.hit_count, want.miss_count, want.occupancy, want.last_result);
               $display("  got found=%0d key=%h val=%h ev=%0d ek=%h evv=%h st=%0d",
                        got.found, got.key_out, got.value_out, got.evicted,
                        got.evicted_key, got.evicted_value, got.status);
               $display("      hit=%0d miss=%0d occ=%0d last=%0d",
                        got.hit_count, got.miss_count, got.occupancy, got.last_result);
            end
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [4:0] csr_wr_data;
   longint     cycles;
   int         items_sent;
   logic [31:0] key_pool[8];

   lkvc_req_if req_ch ();
   lkvc_rsp_if rsp_ch ();

   lru_key_value_cache u_top (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch.sink),
      .rsp_ch     (rsp_ch.source),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   cache_scoreboard cache_sb;

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // receiver stall pattern, with calm stretches
   initial begin
      int mode;
      rsp_ch.ready = 0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
         case (mode)
            0: rsp_ch.ready <= 1;
            1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      beat_type b;
      cycles <= cycles + 1;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         b.found = rsp_ch.found;
         b.key_out = rsp_ch.key_out;
         b.value_out = rsp_ch.value_out;
         b.evicted = rsp_ch.evicted;
         b.evicted_key = rsp_ch.evicted_key;
         b.evicted_value = rsp_ch.evicted_value;
         b.status = rsp_ch.status;
         b.hit_count = rsp_ch.hit_count;
         b.miss_count = rsp_ch.miss_count;
         b.occupancy = rsp_ch.occupancy;
         b.last_result = rsp_ch.last_result;
         cache_sb.check_beat(b);
      end
      if (cycles > 400000) begin
         $display("timeout after %0d cycles", cycles);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // hold valid until the beat is taken; called right after a negedge
   task automatic send_request(lkvc_pkg::op_type op, logic [31:0] k, logic [31:0] v);
      req_ch.valid <= 1;
      req_ch.operation <= op;
      req_ch.key_in <= k;
      req_ch.value_in <= v;
      do @(posedge clock); while (!req_ch.ready);
      cache_sb.note_request(op, k, v);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic pause_sender();
      int gap;
      gap = $urandom_range(1, 6);
      req_ch.valid <= 0;
      repeat (gap) @(negedge clock);
   endtask

   task automatic drain_and_write_capacity(logic [4:0] c);
      req_ch.valid <= 0;
      while (cache_sb.pending.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= c;
      @(negedge clock);
      csr_wr_en <= 0;
      cache_sb.write_capacity(c);
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_key();
      if ($urandom_range(0, 9) == 0) return $urandom;
      return key_pool[$urandom_range(0, 7)];
   endfunction

   task automatic random_phase(int count);
      int burst;
      lkvc_pkg::op_type op;
      burst = 0;
      for (int n = 0; n < count; n++) begin
         if (burst == 0) begin
            burst = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0) pause_sender();
         end
         burst--;
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6: op = lkvc_pkg::OP_PUT;
            7, 8, 9: op = lkvc_pkg::OP_GET;
            19: op = lkvc_pkg::op_type'($urandom_range(0, 15));
            default: op = lkvc_pkg::op_type'($urandom_range(0, 10));
         endcase
         // keep clears rare so the store fills up
         if (op == lkvc_pkg::OP_CLEAR && $urandom_range(0, 3) != 0) op = lkvc_pkg::OP_PUT;
         send_request(op, pick_key(), $urandom);
      end
   endtask

   initial begin
      cache_sb = new();
      cache_sb.clear_all();
      cache_sb.cap = 16;
      cycles = 0;
      items_sent = 0;
      reset = 1;
      csr_wr_en = 0;
      csr_wr_data = 0;
      req_ch.valid = 0;
      req_ch.operation = lkvc_pkg::OP_GET;
      req_ch.key_in = 0;
      req_ch.value_in = 0;
      for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
      key_pool[0] = 32'h0;
      key_pool[1] = 32'hFFFF_FFFF;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // empty store corner cases, then a filled store
      send_request(lkvc_pkg::OP_LIST, 0, 0);
      send_request(lkvc_pkg::OP_POP_OLDEST, 0, 0);
      send_request(lkvc_pkg::OP_POP_NEWEST, 0, 0);
      send_request(lkvc_pkg::OP_PEEK_NEWEST, 0, 0);
      send_request(lkvc_pkg::OP_PEEK_OLDEST, 0, 0);
      send_request(lkvc_pkg::OP_GET, 32'h0, 0);
      send_request(lkvc_pkg::OP_POP, 32'hFFFF_FFFF, 0);
      send_request(lkvc_pkg::OP_DELETE, 32'h5, 0);
      send_request(lkvc_pkg::OP_CONTAINS, 32'h5, 0);
      send_request(lkvc_pkg::OP_PUT, 32'h0, 32'hFFFF_FFFF);
      send_request(lkvc_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0);
      send_request(lkvc_pkg::OP_PUT, 32'h0, 32'h1234_5678);
      send_request(lkvc_pkg::OP_CONTAINS, 32'hFFFF_FFFF, 0);
      send_request(lkvc_pkg::OP_GET, 32'hFFFF_FFFF, 0);
      send_request(lkvc_pkg::OP_PEEK_OLDEST, 0, 0);
      send_request(lkvc_pkg::OP_PEEK_NEWEST, 0, 0);
      send_request(lkvc_pkg::OP_LIST, 0, 0);
      send_request(4'd11, 32'h1, 32'h1);
      send_request(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(lkvc_pkg::OP_POP, 32'h0, 0);
      send_request(lkvc_pkg::OP_POP_NEWEST, 0, 0);
      send_request(lkvc_pkg::OP_PUT, 32'h7, 32'h7);
      send_request(lkvc_pkg::OP_POP_OLDEST, 0, 0);
      send_request(lkvc_pkg::OP_CLEAR, 0, 0);

      drain_and_write_capacity(5'd1);
      random_phase(15);
      send_request(lkvc_pkg::OP_CLEAR, 0, 0);
      drain_and_write_capacity(5'd0);
      random_phase(10);
      send_request(lkvc_pkg::OP_CLEAR, 0, 0);
      drain_and_write_capacity(5'd3);
      random_phase(20);
      send_request(lkvc_pkg::OP_LIST, 0, 0);
      send_request(lkvc_pkg::OP_CLEAR, 0, 0);
      drain_and_write_capacity(5'd31);
      random_phase(30);
      send_request(lkvc_pkg::OP_LIST, 0, 0);
      send_request(lkvc_pkg::OP_CLEAR, 0, 0);
      drain_and_write_capacity(5'd16);
      // write while entries are held must be ignored
      send_request(lkvc_pkg::OP_PUT, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
      drain_and_write_capacity(5'd2);
      random_phase(20);
      send_request(lkvc_pkg::OP_LIST, 0, 0);

      req_ch.valid <= 0;
      while (cache_sb.pending.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      $display("Sent %0d requests, checked %0d result beats over capacities 1, 3 and 16",
               items_sent, cache_sb.beats_checked);
      $display("plus empty-store corners, unknown codes and a capacity write held off");
      if (cache_sb.mismatches == 0) $display("Simulation PASSED");
      else begin
         $display("%0d mismatches", cache_sb.mismatches);
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
